// ===== sv/path_gradient_smoother_macros.svh =====
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef PATH_GRADIENT_SMOOTHER_MACROS_SVH
`define PATH_GRADIENT_SMOOTHER_MACROS_SVH

// Same-cycle implication.
`define PGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pgs_pkg.sv =====
package pgs_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int FIELD_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int TOL_W      = 24;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int DIFF_LIM_LOG2 = 46;
  localparam int FRAC_BITS     = 16;
  localparam int SHORT_PATH    = 3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_DATA_RST   = 16'd6554;
  localparam logic [WEIGHT_W-1:0] WEIGHT_SMOOTH_RST = 16'd32768;
  localparam logic [TOL_W-1:0]    TOLERANCE_RST     = 24'd1;
  localparam logic [ITER_W-1:0]   MAX_ITER_RST      = 16'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DATA   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SMOOTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER      = 8'd3;

  typedef struct packed {
    logic ld_en;
    logic rd_en;
    logic take_left;
    logic take_cur;
    logic calc_diff;
    logic calc_mult;
    logic upd_en;
  } lane_ctl_t;

endpackage

// ===== sv/pgs_if.sv =====
interface pgs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pgs_pkg::FIELD_W-1:0]  coord_x;
  logic signed [pgs_pkg::FIELD_W-1:0]  coord_y;
  logic                                last_point;

  modport source (output valid, output coord_x, output coord_y, output last_point,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input last_point,
                  output ready);
endinterface

interface pgs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pgs_pkg::FIELD_W-1:0]  smooth_x;
  logic signed [pgs_pkg::FIELD_W-1:0]  smooth_y;
  logic                                last_out;
  logic                                converged;

  modport source (output valid, output smooth_x, output smooth_y, output last_out,
                  output converged, input ready);
  modport sink   (input valid, input smooth_x, input smooth_y, input last_out,
                  input converged, output ready);
endinterface

interface pgs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pgs_pkg::CFG_IDX_W-1:0]        index;
  logic [pgs_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pgs_lane.sv =====
module pgs_lane #(
  parameter int MAX_POINTS  = pgs_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pgs_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  pgs_pkg::lane_ctl_t                    ctl,
  input  logic [$clog2(MAX_POINTS)-1:0]         addr_o,
  input  logic [$clog2(MAX_POINTS)-1:0]         addr_w,
  input  logic signed [pgs_pkg::FIELD_W-1:0]    ld_data,
  input  logic [pgs_pkg::WEIGHT_W-1:0]          weight_data,
  input  logic [pgs_pkg::WEIGHT_W-1:0]          weight_smooth,
  output logic signed [COORD_WIDTH-1:0]         rd_data,
  output logic                                  chg_v,
  output logic [COORD_WIDTH-1:0]                chg
);

  localparam int CW  = COORD_WIDTH;
  localparam int CW1 = CW + 1;
  localparam int IW  = (CW > pgs_pkg::FIELD_W) ? CW + 1 : pgs_pkg::FIELD_W + 1;
  localparam int RW  = (CW + 3 > 48) ? CW + 3 : 48;
  localparam int DW  = (CW + 2 < 48) ? CW + 2 : 48;
  localparam int SW  = pgs_pkg::WEIGHT_W + 1;
  localparam int PW  = DW + SW;
  localparam int XW  = PW + 2;

  localparam logic signed [RW-1:0] DLIM     = RW'(64'd1 << pgs_pkg::DIFF_LIM_LOG2);
  localparam logic signed [RW-1:0] DLIM_NEG = -DLIM;
  localparam logic signed [XW-1:0] XMAX     = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN     = ~XMAX;
  localparam logic signed [IW-1:0] IMAX     = {{(IW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN     = ~IMAX;
  localparam logic signed [XW-1:0] RND      = XW'(64'd1 << (pgs_pkg::FRAC_BITS - 1));

  logic signed [CW-1:0] orig_mem [MAX_POINTS];
  logic signed [CW-1:0] work_mem [MAX_POINTS];

  logic signed [CW-1:0] orig_q_r, work_q_r;
  logic signed [CW-1:0] left_r, cur_r, right_r;
  logic signed [DW-1:0] dd_r, ds_r;
  logic signed [PW-1:0] pd_r, ps_r;
  logic                 chg_v_r;
  logic [CW-1:0]        chg_r;

  logic signed [IW-1:0] ld_ext;
  logic signed [CW-1:0] ld_sat;
  logic signed [RW-1:0] dd_raw, ds_raw, dd_sat, ds_sat;
  logic signed [SW-1:0] wd_s, ws_s;
  logic signed [PW-1:0] pd_nxt, ps_nxt;
  logic signed [XW-1:0] t_sum, delta, upd_raw;
  logic signed [CW-1:0] upd_nxt;
  logic signed [CW1-1:0] chg_diff, chg_abs;
  logic signed [CW-1:0] wr_data;

  always_comb begin
    ld_ext = IW'(ld_data);
    if (ld_ext > IMAX) begin
      ld_sat = CW'(IMAX);
    end else if (ld_ext < IMIN) begin
      ld_sat = CW'(IMIN);
    end else begin
      ld_sat = CW'(ld_ext);
    end
  end

  always_comb begin
    dd_raw = RW'(orig_q_r) - RW'(cur_r);
    ds_raw = RW'(left_r) + RW'(work_q_r) - (RW'(cur_r) <<< 1);
    if (dd_raw > DLIM) begin
      dd_sat = DLIM;
    end else if (dd_raw < DLIM_NEG) begin
      dd_sat = DLIM_NEG;
    end else begin
      dd_sat = dd_raw;
    end
    if (ds_raw > DLIM) begin
      ds_sat = DLIM;
    end else if (ds_raw < DLIM_NEG) begin
      ds_sat = DLIM_NEG;
    end else begin
      ds_sat = ds_raw;
    end
  end

  assign wd_s   = $signed({1'b0, weight_data});
  assign ws_s   = $signed({1'b0, weight_smooth});
  assign pd_nxt = wd_s * dd_r;
  assign ps_nxt = ws_s * ds_r;

  always_comb begin
    t_sum   = XW'(pd_r) + XW'(ps_r) + RND;
    delta   = t_sum >>> pgs_pkg::FRAC_BITS;
    upd_raw = XW'(cur_r) + delta;
    if (upd_raw > XMAX) begin
      upd_nxt = CW'(XMAX);
    end else if (upd_raw < XMIN) begin
      upd_nxt = CW'(XMIN);
    end else begin
      upd_nxt = CW'(upd_raw);
    end
    chg_diff = CW1'(cur_r) - CW1'(upd_nxt);
    chg_abs  = chg_diff[CW] ? -chg_diff : chg_diff;
  end

  assign wr_data = ctl.ld_en ? ld_sat : upd_nxt;

  always_ff @(posedge clk) begin
    if (ctl.ld_en) begin
      orig_mem[addr_o] <= ld_sat;
    end
    if (ctl.ld_en || ctl.upd_en) begin
      work_mem[addr_o] <= wr_data;
    end
    if (ctl.rd_en) begin
      orig_q_r <= orig_mem[addr_o];
      work_q_r <= work_mem[addr_w];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_left) begin
      left_r <= work_q_r;
    end
    if (ctl.take_cur) begin
      cur_r <= work_q_r;
    end
    if (ctl.calc_diff) begin
      dd_r    <= DW'(dd_sat);
      ds_r    <= DW'(ds_sat);
      right_r <= work_q_r;
    end
    if (ctl.calc_mult) begin
      pd_r <= pd_nxt;
      ps_r <= ps_nxt;
    end
    chg_v_r <= ctl.upd_en;
    if (ctl.upd_en) begin
      left_r <= upd_nxt;
      cur_r  <= right_r;
      chg_r  <= chg_abs[CW-1:0];
    end
  end

  assign rd_data = work_q_r;
  assign chg_v   = chg_v_r;
  assign chg     = chg_r;

endmodule

// ===== sv/pgs_merge.sv =====
module pgs_merge #(
  parameter int MAX_POINTS  = pgs_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pgs_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          clr,
  input  logic                          chg_v,
  input  logic [COORD_WIDTH-1:0]        chg_x,
  input  logic [COORD_WIDTH-1:0]        chg_y,
  input  logic [pgs_pkg::TOL_W-1:0]     tolerance,
  output logic                          below_tol
);

  localparam int ACC_W = COORD_WIDTH + 1 + $clog2(MAX_POINTS);
  localparam int CMP_W = (ACC_W > pgs_pkg::TOL_W) ? ACC_W : pgs_pkg::TOL_W;

  logic [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (chg_v) begin
      acc_r <= acc_r + ACC_W'(chg_x) + ACC_W'(chg_y);
    end
  end

  assign below_tol = CMP_W'(acc_r) < CMP_W'(tolerance);

endmodule

// ===== sv/path_gradient_smoother.sv =====
// Gradient-descent path smoother for 2-D waypoints in signed Q16.16.
// in_chan: one waypoint per transaction; in_chan.ready is high while the block
//   is loading, so a path streams in at one point per cycle. last_point closes
//   the path and starts smoothing (points beyond MAX_POINTS are dropped).
// cfg_chan: register writes, always ready; write only while the block is idle.
// Smoothing: the x and y lanes update side by side; each interior point passes
//   through read, difference, multiply and update in turn, because each update
//   needs the freshly updated left neighbour. A sweep primes the left neighbour
//   and first interior point, updates the interior in order, then drains; sweeps
//   repeat until the summed change drops below the tolerance or the cap is hit.
// out_chan: every point of the path, in order, with last_out on the final one
//   and converged on all. An output register parts the channel: each point is
//   read in S_EMIT_RD once the register is free and loaded in S_EMIT_WR; a
//   stall holds the current point and pauses the readout. Paths of fewer than
//   three points are emitted unchanged right after the last point.
// in_chan.ready returns as the final point enters the output register.
// Reset (synchronous, active low) empties the path and restores the register
// defaults; the point stores need no clearing.
`include "path_gradient_smoother_macros.svh"

module path_gradient_smoother #(
  parameter int MAX_POINTS  = pgs_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pgs_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pgs_in_if.sink     in_chan,
  pgs_out_if.source  out_chan,
  pgs_cfg_if.sink    cfg_chan
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = COORD_WIDTH;
  localparam int OW    = (CW > pgs_pkg::FIELD_W) ? CW : pgs_pkg::FIELD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE_A, S_PRE_B, S_P0, S_P1, S_P2, S_P3,
    S_DRAIN, S_CHECK, S_EMIT_RD, S_EMIT_WR
  } state_t;

  state_t                          state_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [AW-1:0]                   pt_r;
  logic [pgs_pkg::ITER_W-1:0]      iter_r;
  logic                            conv_r;
  logic [pgs_pkg::WEIGHT_W-1:0]    wd_r, ws_r;
  logic [pgs_pkg::TOL_W-1:0]       tol_r;
  logic [pgs_pkg::ITER_W-1:0]      miter_r;
  logic                            out_valid_r;
  logic signed [pgs_pkg::FIELD_W-1:0] out_x_r, out_y_r;
  logic                            out_last_r, out_conv_r;

  pgs_pkg::lane_ctl_t              ctl;
  logic [AW-1:0]                   addr_o, addr_w;
  logic signed [CW-1:0]            rd_x, rd_y;
  logic                            chg_v_x, chg_v_y;
  logic [CW-1:0]                   chg_x, chg_y;
  logic                            below_tol;
  logic                            in_fire, out_fire, cfg_fire, ld_ok;
  logic [CNT_W-1:0]                n_nxt;
  logic [pgs_pkg::ITER_W-1:0]      cap;
  logic                            out_free;
  logic signed [OW-1:0]            ox_ext, oy_ext;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign ld_ok    = cnt_r < CNT_W'(MAX_POINTS);
  assign n_nxt    = ld_ok ? cnt_r + CNT_W'(1) : cnt_r;
  assign cap      = (miter_r == '0) ? pgs_pkg::ITER_W'(1) : miter_r;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    ctl           = '0;
    ctl.ld_en     = in_fire && ld_ok;
    ctl.rd_en     = (state_r == S_PRE_A) || (state_r == S_PRE_B) ||
                    (state_r == S_P0) || (state_r == S_EMIT_RD);
    ctl.take_left = (state_r == S_PRE_B);
    ctl.take_cur  = (state_r == S_P0) && (pt_r == AW'(1));
    ctl.calc_diff = (state_r == S_P1);
    ctl.calc_mult = (state_r == S_P2);
    ctl.upd_en    = (state_r == S_P3);
  end

  always_comb begin
    addr_o = (state_r == S_IDLE) ? cnt_r[AW-1:0] : pt_r;
    unique case (state_r)
      S_PRE_A: addr_w = '0;
      S_PRE_B: addr_w = AW'(1);
      S_P0:    addr_w = pt_r + AW'(1);
      default: addr_w = pt_r;
    endcase
  end

  pgs_lane #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_lane_x (
    .clk           (clk),
    .ctl           (ctl),
    .addr_o        (addr_o),
    .addr_w        (addr_w),
    .ld_data       (in_chan.coord_x),
    .weight_data   (wd_r),
    .weight_smooth (ws_r),
    .rd_data       (rd_x),
    .chg_v         (chg_v_x),
    .chg           (chg_x)
  );

  pgs_lane #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_lane_y (
    .clk           (clk),
    .ctl           (ctl),
    .addr_o        (addr_o),
    .addr_w        (addr_w),
    .ld_data       (in_chan.coord_y),
    .weight_data   (wd_r),
    .weight_smooth (ws_r),
    .rd_data       (rd_y),
    .chg_v         (chg_v_y),
    .chg           (chg_y)
  );

  pgs_merge #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_merge (
    .clk       (clk),
    .clr       (state_r == S_PRE_A),
    .chg_v     (chg_v_x),
    .chg_x     (chg_x),
    .chg_y     (chg_y),
    .tolerance (tol_r),
    .below_tol (below_tol)
  );

  assign ox_ext = OW'(rd_x);
  assign oy_ext = OW'(rd_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pt_r        <= '0;
      iter_r      <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wd_r        <= pgs_pkg::WEIGHT_DATA_RST;
      ws_r        <= pgs_pkg::WEIGHT_SMOOTH_RST;
      tol_r       <= pgs_pkg::TOLERANCE_RST;
      miter_r     <= pgs_pkg::MAX_ITER_RST;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_chan.index)
          pgs_pkg::REG_WEIGHT_DATA:   wd_r    <= cfg_chan.data[pgs_pkg::WEIGHT_W-1:0];
          pgs_pkg::REG_WEIGHT_SMOOTH: ws_r    <= cfg_chan.data[pgs_pkg::WEIGHT_W-1:0];
          pgs_pkg::REG_TOLERANCE:     tol_r   <= cfg_chan.data[pgs_pkg::TOL_W-1:0];
          pgs_pkg::REG_MAX_ITER:      miter_r <= cfg_chan.data[pgs_pkg::ITER_W-1:0];
          default: ;
        endcase
      end
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cnt_r <= n_nxt;
            if (in_chan.last_point) begin
              pt_r   <= '0;
              iter_r <= '0;
              if (n_nxt < CNT_W'(pgs_pkg::SHORT_PATH)) begin
                conv_r  <= 1'b1;
                state_r <= S_EMIT_RD;
              end else begin
                state_r <= S_PRE_A;
              end
            end
          end
        end
        S_PRE_A: begin
          pt_r    <= AW'(1);
          state_r <= S_PRE_B;
        end
        S_PRE_B: state_r <= S_P0;
        S_P0:    state_r <= S_P1;
        S_P1:    state_r <= S_P2;
        S_P2:    state_r <= S_P3;
        S_P3: begin
          if (CNT_W'(pt_r) + CNT_W'(2) == cnt_r) begin
            state_r <= S_DRAIN;
          end else begin
            pt_r    <= pt_r + AW'(1);
            state_r <= S_P0;
          end
        end
        S_DRAIN: begin
          iter_r  <= iter_r + pgs_pkg::ITER_W'(1);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          pt_r <= '0;
          if (below_tol) begin
            conv_r  <= 1'b1;
            state_r <= S_EMIT_RD;
          end else if (iter_r >= cap) begin
            conv_r  <= 1'b0;
            state_r <= S_EMIT_RD;
          end else begin
            state_r <= S_PRE_A;
          end
        end
        S_EMIT_RD: begin
          if (out_free) begin
            state_r <= S_EMIT_WR;
          end
        end
        S_EMIT_WR: begin
          out_valid_r <= 1'b1;
          out_x_r     <= ox_ext[pgs_pkg::FIELD_W-1:0];
          out_y_r     <= oy_ext[pgs_pkg::FIELD_W-1:0];
          out_conv_r  <= conv_r;
          out_last_r  <= (CNT_W'(pt_r) + CNT_W'(1) == cnt_r);
          if (CNT_W'(pt_r) + CNT_W'(1) == cnt_r) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            pt_r    <= pt_r + AW'(1);
            state_r <= S_EMIT_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.smooth_x  = out_x_r;
  assign out_chan.smooth_y  = out_y_r;
  assign out_chan.last_out  = out_last_r;
  assign out_chan.converged = out_conv_r;

  `PGS_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= CNT_W'(MAX_POINTS), "point count overflow")
  `PGS_ASSERT_IMP(a_lanes_lockstep, 1'b1, chg_v_x == chg_v_y, "lanes out of step")
  `PGS_ASSERT_IMP(a_sweep_window, state_r == S_P0, (pt_r != '0) && (CNT_W'(pt_r) + CNT_W'(2) <= cnt_r), "sweep index outside interior")
  `PGS_ASSERT_NXT(a_emit_loads, state_r == S_EMIT_WR, out_valid_r, "emitted point not shown")
  `PGS_ASSERT_IMP(a_check_after_sweep, state_r == S_CHECK, iter_r != '0, "check without a sweep")

endmodule

// ===== dv/tb_path_gradient_smoother.sv =====
module tb_path_gradient_smoother;

  localparam int MAX_PTS = pgs_pkg::MAX_POINTS_DEF;
  localparam longint DIFF_CAP = longint'(1) << pgs_pkg::DIFF_LIM_LOG2;
  localparam longint COORD_HI = (longint'(1) << (pgs_pkg::COORD_WIDTH_DEF - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint unsigned CHANGE_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [pgs_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd4;
  localparam logic [pgs_pkg::CFG_IDX_W-1:0] REG_TOP = 8'hFF;
  localparam int DRAIN_LIMIT = 400_000;

  typedef enum {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} spread_t;

  typedef struct {
    logic signed [pgs_pkg::FIELD_W-1:0] x;
    logic signed [pgs_pkg::FIELD_W-1:0] y;
    logic last;
    logic conv;
  } waypoint_t;

  logic clk = 1'b0;
  logic rst_n;

  pgs_in_if  in_chan ();
  pgs_out_if out_chan ();
  pgs_cfg_if cfg_chan ();

  path_gradient_smoother DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #16_000_000;
    $display("Verification failed");
    $finish;
  end

  // Shadow of the smoother state and registers
  longint orig_x [MAX_PTS];
  longint orig_y [MAX_PTS];
  longint work_x [MAX_PTS];
  longint work_y [MAX_PTS];
  int stored = 0;

  logic [pgs_pkg::WEIGHT_W-1:0] cur_wd = pgs_pkg::WEIGHT_DATA_RST;
  logic [pgs_pkg::WEIGHT_W-1:0] cur_ws = pgs_pkg::WEIGHT_SMOOTH_RST;
  logic [pgs_pkg::TOL_W-1:0]    cur_tol = pgs_pkg::TOLERANCE_RST;
  logic [pgs_pkg::ITER_W-1:0]   cur_cap = pgs_pkg::MAX_ITER_RST;

  waypoint_t expected_points [$];

  bit lazy = 1'b0;
  int hold_off = 0;
  int errors = 0;
  int points_sent = 0;
  int paths_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int unconverged = 0;

  task automatic flag_mismatch(input string msg);
    if (errors < 50) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
    return (a > CHANGE_CAP - b) ? CHANGE_CAP : a + b;
  endfunction

  function automatic longint unsigned distance(longint a, longint b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic longint relax(longint o, longint l, longint c, longint r);
    longint dd;
    longint ds;
    longint t;
    dd = clip(o - c, -DIFF_CAP, DIFF_CAP);
    ds = clip(l + r - 2 * c, -DIFF_CAP, DIFF_CAP);
    t = longint'(cur_wd) * dd + longint'(cur_ws) * ds;
    return clip(c + ((t + 32768) >>> pgs_pkg::FRAC_BITS), COORD_LO, COORD_HI);
  endfunction

  function automatic bit smooth_path(int n);
    int cap;
    int iter;
    longint px;
    longint py;
    longint unsigned change;
    cap = (cur_cap == 0) ? 1 : int'(cur_cap);
    iter = 0;
    if (n < pgs_pkg::SHORT_PATH) return 1'b1;
    forever begin
      change = 0;
      for (int i = 1; i + 1 < n; i++) begin
        px = work_x[i];
        py = work_y[i];
        work_x[i] = relax(orig_x[i], work_x[i-1], px, work_x[i+1]);
        work_y[i] = relax(orig_y[i], work_y[i-1], py, work_y[i+1]);
        change = sat_add(change, distance(px, work_x[i]));
        change = sat_add(change, distance(py, work_y[i]));
      end
      iter++;
      if (change < cur_tol) return 1'b1;
      if (iter >= cap) return 1'b0;
    end
  endfunction

  function automatic void absorb_point(logic signed [pgs_pkg::FIELD_W-1:0] x,
                                       logic signed [pgs_pkg::FIELD_W-1:0] y,
                                       logic last);
    waypoint_t wp;
    int n;
    bit conv;
    if (stored < MAX_PTS) begin
      orig_x[stored] = x;
      orig_y[stored] = y;
      work_x[stored] = x;
      work_y[stored] = y;
      stored++;
    end
    if (!last) return;
    n = stored;
    conv = smooth_path(n);
    if (!conv) unconverged++;
    for (int i = 0; i < n; i++) begin
      wp.x = work_x[i][pgs_pkg::FIELD_W-1:0];
      wp.y = work_y[i][pgs_pkg::FIELD_W-1:0];
      wp.last = (i == n - 1);
      wp.conv = conv;
      expected_points.insert(expected_points.size(), wp);
    end
    stored = 0;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!lazy || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_chan.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (lazy && $urandom_range(0, 3) == 0) hold_off <= idle_len();
    end
  end

  always @(posedge clk) begin
    waypoint_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_points.size() == 0) begin
        flag_mismatch($sformatf("unexpected point x=%h y=%h", out_chan.smooth_x,
                                out_chan.smooth_y));
      end else begin
        want = expected_points.pop_front();
        if (out_chan.smooth_x !== want.x)
          flag_mismatch($sformatf("result %0d: smooth_x %h, expected %h",
                                  results_checked, out_chan.smooth_x, want.x));
        if (out_chan.smooth_y !== want.y)
          flag_mismatch($sformatf("result %0d: smooth_y %h, expected %h",
                                  results_checked, out_chan.smooth_y, want.y));
        if (out_chan.last_out !== want.last)
          flag_mismatch($sformatf("result %0d: last_out %b, expected %b",
                                  results_checked, out_chan.last_out, want.last));
        if (out_chan.converged !== want.conv)
          flag_mismatch($sformatf("result %0d: converged %b, expected %b",
                                  results_checked, out_chan.converged, want.conv));
      end
      results_checked++;
    end
  end

  task automatic send_point(logic [pgs_pkg::FIELD_W-1:0] x, logic [pgs_pkg::FIELD_W-1:0] y,
                            logic last);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.coord_x <= x;
    in_chan.coord_y <= y;
    in_chan.last_point <= last;
    do @(posedge clk); while (!in_chan.ready);
    absorb_point(x, y, last);
    points_sent++;
  endtask

  task automatic write_reg(logic [pgs_pkg::CFG_IDX_W-1:0] idx,
                           logic [pgs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      pgs_pkg::REG_WEIGHT_DATA:   cur_wd = val[pgs_pkg::WEIGHT_W-1:0];
      pgs_pkg::REG_WEIGHT_SMOOTH: cur_ws = val[pgs_pkg::WEIGHT_W-1:0];
      pgs_pkg::REG_TOLERANCE:     cur_tol = val[pgs_pkg::TOL_W-1:0];
      pgs_pkg::REG_MAX_ITER:      cur_cap = val[pgs_pkg::ITER_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic configure(logic [pgs_pkg::CFG_DATA_W-1:0] wd,
                           logic [pgs_pkg::CFG_DATA_W-1:0] ws,
                           logic [pgs_pkg::CFG_DATA_W-1:0] tol,
                           logic [pgs_pkg::CFG_DATA_W-1:0] cap);
    write_reg(pgs_pkg::REG_WEIGHT_DATA, wd);
    write_reg(pgs_pkg::REG_WEIGHT_SMOOTH, ws);
    write_reg(pgs_pkg::REG_TOLERANCE, tol);
    write_reg(pgs_pkg::REG_MAX_ITER, cap);
  endtask

  // Hold the input idle until every expected point has come out; flag any still missing at DRAIN_LIMIT
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_points.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_points.size() != 0) begin
      flag_mismatch($sformatf("%0d expected points never arrived",
                              expected_points.size()));
      expected_points.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [pgs_pkg::FIELD_W-1:0] pick_coord(spread_t s,
                                                             logic [pgs_pkg::FIELD_W-1:0] base);
    case (s)
      SPREAD_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
      SPREAD_NEAR: return base + $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_path(int n, spread_t s);
    logic [pgs_pkg::FIELD_W-1:0] base;
    base = $urandom;
    for (int i = 0; i < n; i++)
      send_point(pick_coord(s, base), pick_coord(s, base), i == n - 1);
    paths_sent++;
  endtask

  function automatic int path_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(9, 20);
  endfunction

  task automatic send_random_paths(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = path_len();
      send_path(n, spread_t'($urandom_range(0, 2)));
      sent += n;
    end
  endtask

  task automatic test_directed();
    lazy = 1'b0;
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_path(5, SPREAD_NEAR);
    paths_sent += 4;
    settle();
  endtask

  task automatic test_frozen_weights();
    lazy = 1'b1;
    configure(32'h0, 32'h0, 32'h1, 32'h0000_FFFF);
    send_random_paths(20);
    settle();
  endtask

  task automatic test_saturation();
    lazy = 1'b1;
    configure(32'h0000_FFFF, 32'h0000_FFFF, 32'h0, 32'h1);
    for (int i = 0; i < 3; i++) send_path($urandom_range(3, 5), SPREAD_EDGE);
    settle();
    write_reg(pgs_pkg::REG_MAX_ITER, 32'h2);
    for (int i = 0; i < 3; i++) send_path($urandom_range(3, 5), SPREAD_EDGE);
    settle();
  endtask

  task automatic test_zero_cap();
    lazy = 1'b0;
    configure($urandom, $urandom, 32'h00FF_FFFF, 32'hFFFF_0000);
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_TOP, $urandom);
    send_random_paths(15);
    settle();
  endtask

  task automatic test_store_full();
    lazy = 1'b1;
    configure(pgs_pkg::WEIGHT_DATA_RST, pgs_pkg::WEIGHT_SMOOTH_RST, 32'h0, 32'h3);
    send_path(MAX_PTS + 3, SPREAD_FULL);
    send_path(2, SPREAD_FULL);
    settle();
  endtask

  task automatic test_random_settings();
    logic [pgs_pkg::CFG_DATA_W-1:0] tol;
    for (int phase = 0; phase < 5; phase++) begin
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = $urandom_range(1, 255);
        2: tol = $urandom_range(256, 65535);
        default: tol = $urandom;
      endcase
      configure($urandom, $urandom, tol, $urandom_range(1, 24));
      lazy = ($urandom_range(0, 3) != 0);
      send_random_paths(6);
      settle();
    end
  endtask

  task automatic test_default_settling();
    lazy = 1'b1;
    configure(pgs_pkg::WEIGHT_DATA_RST, pgs_pkg::WEIGHT_SMOOTH_RST,
              pgs_pkg::TOLERANCE_RST, pgs_pkg::MAX_ITER_RST);
    for (int i = 0; i < 4; i++) send_path($urandom_range(3, 6), SPREAD_NEAR);
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.coord_x = '0;
    in_chan.coord_y = '0;
    in_chan.last_point = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_frozen_weights();
    test_saturation();
    test_zero_cap();
    test_store_full();
    test_random_settings();
    test_default_settling();

    $display("Covered %0d waypoints in %0d paths, %0d register writes,",
             points_sent, paths_sent, reg_writes);
    $display("%0d smoothed points checked, %0d paths stopped by the sweep cap.",
             results_checked, unconverged);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
